// ----- sv/hm84_pkg.sv -----
// shared widths, codebook and decode function for the hamming (8,4) stream decoder
package hm84_pkg;

    localparam int CODE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int CNT_W   = 2;
    localparam int TOTAL_W = 32;
    localparam int BOOK_N  = 16;

    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [NIB_W-1:0]   t_nibble;
    typedef logic [CNT_W-1:0]   t_pair_cnt;
    typedef logic [TOTAL_W-1:0] t_total;

    typedef struct packed {
        t_nibble nibble;
        logic    bad;
        logic    corrected;
    } t_decode;

    localparam t_code CODEBOOK [BOOK_N] = '{
        8'h00, 8'hD2, 8'h55, 8'h87, 8'h99, 8'h4B, 8'hCC, 8'h1E,
        8'hE1, 8'h33, 8'hB4, 8'h66, 8'h78, 8'hAA, 8'h2D, 8'hFF
    };

    // codebook distance is 4, so at most one entry can match
    function automatic t_decode decode_word(input t_code word);
        t_decode res;
        t_code   diff;
        res.nibble    = '0;
        res.bad       = 1'b1;
        res.corrected = 1'b0;
        for (int i = 0; i < BOOK_N; i++) begin
            diff = word ^ CODEBOOK[i];
            if ($countones(diff) <= 1) begin
                res.nibble    = NIB_W'(i);
                res.bad       = 1'b0;
                res.corrected = ($countones(diff) == 1);
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/hm84_code_if.sv -----
// input channel carrying one received code word per request
interface hm84_code_if import hm84_pkg::*;;
    logic  valid;
    logic  ready;
    t_code code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

// ----- sv/hm84_data_if.sv -----
// output channel carrying one decoded byte and its error counts per request
interface hm84_data_if import hm84_pkg::*;;
    logic      valid;
    logic      ready;
    t_code     data_byte;
    t_pair_cnt bad_in_byte;
    t_pair_cnt corrected_in_byte;
    t_total    bad_total;

    modport source (output valid, output data_byte, output bad_in_byte,
                    output corrected_in_byte, output bad_total, input ready);
    modport sink   (input valid, input data_byte, input bad_in_byte,
                    input corrected_in_byte, input bad_total, output ready);
endinterface

// ----- sv/hamming_8_4_stream_decoder_top.sv -----
// top level of the extended hamming (8,4) stream decoder
// Accepts one code word per clock cycle unless a stalled output backs it up. Each
// word is captured in an input register, decoded against the 16-entry codebook
// by parallel distance checks, and every second word completes a pair that is
// written into the output register, so a decoded byte passes through the input
// and output registers and one byte is produced per two requests. The input
// register keeps taking words while a finished byte waits at the output; a
// stalled output holds back only the word that completes the next pair.
// Words at distance one are corrected, other non-codewords decode to zero
// and bump a saturating 32-bit count reported with each byte. An unpaired
// last word stays held until another word arrives or reset clears it.
module hamming_8_4_stream_decoder_top import hm84_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hm84_code_if.sink   i_code,
    hm84_data_if.source o_data
);

    logic      r_s1_valid, n_s1_valid;
    t_code     r_s1_code,  n_s1_code;
    logic      r_have_half, n_have_half;
    t_nibble   r_held_nibble, n_held_nibble;
    logic      r_held_bad, n_held_bad;
    logic      r_held_corr, n_held_corr;
    t_total    r_bad_counter, n_bad_counter;
    logic      r_out_valid, n_out_valid;
    t_code     r_out_data, n_out_data;
    t_pair_cnt r_out_bad, n_out_bad;
    t_pair_cnt r_out_corr, n_out_corr;
    t_total    r_out_total, n_out_total;

    t_decode w_dec;
    logic    w_out_free;
    logic    w_s1_go;
    logic    w_in_take;

    assign w_dec      = decode_word(r_s1_code);
    assign w_out_free = !r_out_valid || o_data.ready;
    assign w_s1_go    = r_s1_valid && (!r_have_half || w_out_free);
    assign w_in_take  = i_code.valid && i_code.ready;

    assign i_code.ready             = !r_s1_valid || w_s1_go;
    assign o_data.valid             = r_out_valid;
    assign o_data.data_byte         = r_out_data;
    assign o_data.bad_in_byte       = r_out_bad;
    assign o_data.corrected_in_byte = r_out_corr;
    assign o_data.bad_total         = r_out_total;

    always_comb begin
        n_s1_valid    = r_s1_valid;
        n_s1_code     = r_s1_code;
        n_have_half   = r_have_half;
        n_held_nibble = r_held_nibble;
        n_held_bad    = r_held_bad;
        n_held_corr   = r_held_corr;
        n_bad_counter = r_bad_counter;
        n_out_valid   = r_out_valid && !o_data.ready;
        n_out_data    = r_out_data;
        n_out_bad     = r_out_bad;
        n_out_corr    = r_out_corr;
        n_out_total   = r_out_total;

        if (w_s1_go) begin
            n_s1_valid = 1'b0;
        end
        if (w_in_take) begin
            n_s1_valid = 1'b1;
            n_s1_code  = i_code.code_byte;
        end

        if (w_s1_go) begin
            if (w_dec.bad && (r_bad_counter != '1)) begin
                n_bad_counter = r_bad_counter + TOTAL_W'(1);
            end
            if (!r_have_half) begin
                n_have_half   = 1'b1;
                n_held_nibble = w_dec.nibble;
                n_held_bad    = w_dec.bad;
                n_held_corr   = w_dec.corrected;
            end else begin
                n_have_half   = 1'b0;
                n_held_nibble = '0;
                n_held_bad    = 1'b0;
                n_held_corr   = 1'b0;
                n_out_valid   = 1'b1;
                n_out_data    = {r_held_nibble, w_dec.nibble};
                n_out_bad     = {1'b0, r_held_bad} + {1'b0, w_dec.bad};
                n_out_corr    = {1'b0, r_held_corr} + {1'b0, w_dec.corrected};
                n_out_total   = n_bad_counter;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_have_half   <= 1'b0;
            r_held_nibble <= '0;
            r_held_bad    <= 1'b0;
            r_held_corr   <= 1'b0;
            r_bad_counter <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_s1_valid    <= n_s1_valid;
            r_have_half   <= n_have_half;
            r_held_nibble <= n_held_nibble;
            r_held_bad    <= n_held_bad;
            r_held_corr   <= n_held_corr;
            r_bad_counter <= n_bad_counter;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_code   <= n_s1_code;
        r_out_data  <= n_out_data;
        r_out_bad   <= n_out_bad;
        r_out_corr  <= n_out_corr;
        r_out_total <= n_out_total;
    end

    // a new byte only appears after a held half met a second decoded word
    a_out_from_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_have_half))
        else $error("output byte without a completed pair");

    // the error counter never goes backwards outside reset
    a_counter_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_bad_counter >= $past(r_bad_counter)))
        else $error("uncorrectable count decreased");

    // a word is either bad or corrected, never both, so the pair counts fit in two
    a_pair_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out_bad} + {1'b0, r_out_corr} <= 3'd2))
        else $error("pair error counts exceed two words");

    // held flags are clear whenever no half is held
    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_half |-> (!r_held_bad && !r_held_corr && (r_held_nibble == '0)))
        else $error("stale held half");

endmodule

// ----- bench/hm84_checker.sv -----
// scoreboard for the hamming (8,4) stream decoder: pairs decoded words and compares output bytes
module hm84_checker import hm84_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hm84_code_if    i_code,
    hm84_data_if    i_data,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_code     data_byte;
        t_pair_cnt bad_in_byte;
        t_pair_cnt corrected_in_byte;
        t_total    bad_total;
    } t_packed_byte;

    t_packed_byte pending_bytes [$];

    t_nibble first_nibble;
    logic    first_held;
    logic    first_bad;
    logic    first_corrected;
    t_total  uncorrectable_total;

    function automatic int bit_weight(input t_code v);
        int n;
        n = 0;
        for (int b = 0; b < CODE_W; b++) begin
            n += v[b];
        end
        return n;
    endfunction

    // nearest codebook entry within one bit, otherwise uncorrectable
    function automatic void match_codeword(input t_code w, output t_nibble nib,
                                           output logic bad, output logic corr);
        int bit_dist;
        nib  = '0;
        bad  = 1'b1;
        corr = 1'b0;
        for (int e = 0; e < BOOK_N; e++) begin
            bit_dist = bit_weight(w ^ CODEBOOK[e]);
            if (bit_dist <= 1) begin
                nib  = NIB_W'(e);
                bad  = 1'b0;
                corr = (bit_dist == 1);
            end
        end
    endfunction

    task automatic absorb_word(input t_code w);
        t_nibble      nib;
        logic         bad;
        logic         corr;
        t_packed_byte exp_byte;
        match_codeword(w, nib, bad, corr);
        if (bad && uncorrectable_total != '1) begin
            uncorrectable_total++;
        end
        if (!first_held) begin
            first_nibble    = nib;
            first_bad       = bad;
            first_corrected = corr;
            first_held      = 1'b1;
        end else begin
            exp_byte.data_byte         = {first_nibble, nib};
            exp_byte.bad_in_byte       = t_pair_cnt'(first_bad) + t_pair_cnt'(bad);
            exp_byte.corrected_in_byte = t_pair_cnt'(first_corrected) + t_pair_cnt'(corr);
            exp_byte.bad_total         = uncorrectable_total;
            pending_bytes = {pending_bytes, exp_byte};
            first_held      = 1'b0;
            first_nibble    = '0;
            first_bad       = 1'b0;
            first_corrected = 1'b0;
        end
    endtask

    task automatic compare_byte();
        t_packed_byte exp_byte;
        if (pending_bytes.size() == 0) begin
            $error("unexpected output byte %0h", i_data.data_byte);
            o_fail_count++;
        end else begin
            exp_byte = pending_bytes.pop_front();
            if (i_data.data_byte !== exp_byte.data_byte) begin
                $error("data_byte: expected %0h, got %0h",
                       exp_byte.data_byte, i_data.data_byte);
                o_fail_count++;
            end
            if (i_data.bad_in_byte !== exp_byte.bad_in_byte) begin
                $error("bad_in_byte: expected %0d, got %0d",
                       exp_byte.bad_in_byte, i_data.bad_in_byte);
                o_fail_count++;
            end
            if (i_data.corrected_in_byte !== exp_byte.corrected_in_byte) begin
                $error("corrected_in_byte: expected %0d, got %0d",
                       exp_byte.corrected_in_byte, i_data.corrected_in_byte);
                o_fail_count++;
            end
            if (i_data.bad_total !== exp_byte.bad_total) begin
                $error("bad_total: expected %0d, got %0d",
                       exp_byte.bad_total, i_data.bad_total);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count        = 0;
        o_pending           = 0;
        first_nibble        = '0;
        first_held          = 1'b0;
        first_bad           = 1'b0;
        first_corrected     = 1'b0;
        uncorrectable_total = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_bytes.delete();
            first_nibble        = '0;
            first_held          = 1'b0;
            first_bad           = 1'b0;
            first_corrected     = 1'b0;
            uncorrectable_total = '0;
        end else begin
            if (i_code.valid === 1'b1 && i_code.ready === 1'b1) begin
                absorb_word(i_code.code_byte);
            end
            if (i_data.valid === 1'b1 && i_data.ready === 1'b1) begin
                compare_byte();
            end
        end
        o_pending = pending_bytes.size();
    end

endmodule

// ----- bench/testbench.sv -----
// top of the hamming (8,4) stream decoder bench: clock, reset, request stimulus and verdict
module testbench import hm84_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1200;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   burst_left;
    int   rx_left;
    int   rx_phase;
    t_rx_mode rx_mode;

    hm84_code_if code_ch();
    hm84_data_if data_ch();

    hamming_8_4_stream_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (code_ch),
        .o_data  (data_ch)
    );

    hm84_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code       (code_ch),
        .i_data       (data_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(5, 60);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   data_ch.ready <= 1'b1;
            RX_RANDOM: data_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: data_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   data_ch.ready <= (rx_phase % 3 == 0);
        endcase
    end

    task automatic push_word(input t_code w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                code_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
        end
        code_ch.valid     <= 1'b1;
        code_ch.code_byte <= w;
        do @(posedge i_clk); while (code_ch.ready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
    endtask

    function automatic t_code random_word();
        int   kind;
        t_code w;
        kind = $urandom_range(0, 99);
        w    = CODEBOOK[$urandom_range(0, BOOK_N - 1)];
        if (kind >= 75) begin
            w = t_code'($urandom_range(0, 255));
        end else if (kind >= 40) begin
            w = w ^ (t_code'(1) << $urandom_range(0, CODE_W - 1));
        end
        return w;
    endfunction

    initial begin
        i_rst_n           = 1'b0;
        code_ch.valid     = 1'b0;
        code_ch.code_byte = '0;
        data_ch.ready     = 1'b0;
        cycle_count       = 0;
        burst_left        = 0;
        rx_left           = 0;
        rx_phase          = 0;
        rx_mode           = RX_OPEN;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every codeword clean
        for (int e = 0; e < BOOK_N; e++) begin
            push_word(CODEBOOK[e]);
        end
        // two corrected words in one byte
        push_word(8'h01);
        push_word(8'hFE);
        // two uncorrectable words in one byte
        push_word(8'h03);
        push_word(8'hFC);
        // msb flip, paired with the first random word
        push_word(8'h80);

        // odd total leaves a trailing word unpaired
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            push_word(random_word());
        end
        code_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/hm84_pkg.sv
sv/hm84_code_if.sv
sv/hm84_data_if.sv
sv/hamming_8_4_stream_decoder_top.sv
bench/hm84_checker.sv
bench/testbench.sv
